>>> sv/cte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types, codes and constants for the row text escaper.
// ----------------------------------------------------------------------------
package cte_pkg;

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_FIELD = 2'd1,
    MODE_NULL  = 2'd2,
    MODE_ROW   = 2'd3
  } mode_t;

  // Up to three output bytes produced by one request
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  localparam logic [7:0] BACKSLASH     = 8'h5C;
  localparam logic [7:0] LETTER_N      = 8'h4E;
  localparam logic [7:0] DELIM_RESET   = 8'h09;
  localparam int         FIFO_DEPTH    = 4;

  // Letter replacing a control byte, zero if the byte has none
  function automatic logic [7:0] control_letter(input logic [7:0] c);
    logic [7:0] l;
    unique case (c)
      8'h08:   l = 8'h62; // b
      8'h0C:   l = 8'h66; // f
      8'h0A:   l = 8'h6E; // n
      8'h0D:   l = 8'h72; // r
      8'h09:   l = 8'h74; // t
      8'h0B:   l = 8'h76; // v
      default: l = 8'h00;
    endcase
    return l;
  endfunction

endpackage

>>> sv/copy_text_row_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copy_text_row_escaper
// Escapes field bytes and inserts delimiters to build row text.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per accepted cycle (in_valid high, in_stall low).
//            in_mode selects data byte, field start, null field or row start.
//   out_*  : one text byte per accepted cycle; out_last marks the final byte
//            a request produced. Row starts, and field starts with no
//            separator due, produce nothing.
//   cfg_*  : cfg_wr_en writes the delimiter (reset value tab).
// A request's bytes pass through the job queue and then the output register.
// Throughput: one output byte per cycle while out_stall is low and a job is
//   queued, set by the single output register; a request's bytes leave one at
//   a time, and the FIFO_DEPTH job queue lets the input run ahead while escapes drain.
// Reset clears the queue, the output valid flag and the separator flag.
// While out_stall is high the output byte holds; the queue fills and
// in_stall rises once it is full.
// ----------------------------------------------------------------------------
module copy_text_row_escaper #(
  parameter int FIFO_DEPTH = cte_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic          q_push, q_full, q_pop, q_empty;
  cte_pkg::job_t q_job, q_head;

  cte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  cte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  cte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

>>> sv/cte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_front
// Accepts requests, holds the delimiter and separator flag, and turns each
// request into a job of zero to three bytes for the queue.
// ----------------------------------------------------------------------------
module cte_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_mode,
  input  logic [7:0]     in_data_byte,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  input  logic           q_full,
  output logic           q_push,
  output cte_pkg::job_t  q_job
);

  logic [7:0] delim_r;
  logic       need_sep_r, need_sep_nxt;
  logic       accept;
  logic [7:0] letter;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign letter   = cte_pkg::control_letter(in_data_byte);

  always_comb begin
    q_job.count  = 2'd0;
    q_job.b0     = in_data_byte;
    q_job.b1     = in_data_byte;
    q_job.b2     = in_data_byte;
    need_sep_nxt = need_sep_r;
    unique case (cte_pkg::mode_t'(in_mode))
      cte_pkg::MODE_DATA: begin
        if (letter != 8'h00) begin
          q_job.count = 2'd2;
          q_job.b0    = cte_pkg::BACKSLASH;
          q_job.b1    = letter;
        end else if (in_data_byte == cte_pkg::BACKSLASH || in_data_byte == delim_r) begin
          q_job.count = 2'd2;
          q_job.b0    = cte_pkg::BACKSLASH;
          q_job.b1    = in_data_byte;
        end else begin
          q_job.count = 2'd1;
        end
      end
      cte_pkg::MODE_FIELD: begin
        if (need_sep_r) begin
          q_job.count = 2'd1;
          q_job.b0    = delim_r;
        end
        need_sep_nxt = 1'b1;
      end
      cte_pkg::MODE_NULL: begin
        if (need_sep_r) begin
          q_job.count = 2'd3;
          q_job.b0    = delim_r;
          q_job.b1    = cte_pkg::BACKSLASH;
          q_job.b2    = cte_pkg::LETTER_N;
        end else begin
          q_job.count = 2'd2;
          q_job.b0    = cte_pkg::BACKSLASH;
          q_job.b1    = cte_pkg::LETTER_N;
        end
        need_sep_nxt = 1'b1;
      end
      cte_pkg::MODE_ROW: begin
        need_sep_nxt = 1'b0;
      end
      default: begin
        need_sep_nxt = need_sep_r;
      end
    endcase
  end

  // jobs with no bytes never enter the queue
  assign q_push = accept && (q_job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r    <= cte_pkg::DELIM_RESET;
      need_sep_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        delim_r <= cfg_wr_data;
      end
      if (accept) begin
        need_sep_r <= need_sep_nxt;
      end
    end
  end

endmodule

>>> sv/cte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_fifo
// Short job queue between front and back; head is visible while not empty.
// ----------------------------------------------------------------------------
module cte_fifo #(
  parameter int DEPTH = cte_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cte_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cte_pkg::job_t  head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cte_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/cte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module cte_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cte_pkg::job_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_sel;
  logic       last_r, last_sel;
  logic       load;

  assign load     = !q_empty && (!valid_r || !out_stall);
  assign last_sel = (idx_r == 2'(q_head.count - 2'd1));
  assign q_pop    = load && last_sel;

  always_comb begin
    unique case (idx_r)
      2'd0:    byte_sel = q_head.b0;
      2'd1:    byte_sel = q_head.b1;
      2'd2:    byte_sel = q_head.b2;
      default: byte_sel = q_head.b2;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_sel ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_sel;
      last_r <= last_sel;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

>>> sv/cte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_checker
// Port-level checks on the row text escaper, bound to the top level.
// ----------------------------------------------------------------------------
module cte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // output is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output changed");

  // bytes of one request go out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a request");

  // a separator that is not last is followed by the null marker backslash
  a_sep_then_bs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last && out_byte != cte_pkg::BACKSLASH
    |=> out_byte == cte_pkg::BACKSLASH)
    else $error("separator not followed by backslash");

endmodule

bind copy_text_row_escaper cte_checker u_cte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

>>> dv/copy_text_row_escaper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copy_text_row_escaper_test
// Self-checking bench for the row text escaper. A queue-fed driver pushes
// field bytes and field/row events. A monitor predicts the escaped row text
// for every accepted request and checks each output byte and its last flag
// in order. The run covers several delimiter settings and phases of sender
// idling and receiver stalling.
// ----------------------------------------------------------------------------
module copy_text_row_escaper_test;

  typedef struct {
    cte_pkg::mode_t mode;
    logic [7:0]     data;
  } text_req_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } text_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_mode;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  text_req_t  req_queue[$];
  text_byte_t text_due[$];
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         mismatches = 0;
  logic       in_taken = 1'b0;
  logic [7:0] delim_now;
  logic       sep_pending;

  text_req_t  next_req;
  text_byte_t got_byte;

  copy_text_row_escaper u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_data_byte(in_data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected row text for one accepted request
  task automatic predict_text(input cte_pkg::mode_t mode, input logic [7:0] b);
    logic [7:0] seq[3];
    logic [7:0] letter;
    int         n;
    n = 0;
    case (mode)
      cte_pkg::MODE_DATA: begin
        case (b)
          8'h08:   letter = "b";
          8'h0C:   letter = "f";
          8'h0A:   letter = "n";
          8'h0D:   letter = "r";
          8'h09:   letter = "t";
          8'h0B:   letter = "v";
          default: letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
          seq[0] = cte_pkg::BACKSLASH;
          seq[1] = letter;
          n = 2;
        end else if (b == cte_pkg::BACKSLASH || b == delim_now) begin
          seq[0] = cte_pkg::BACKSLASH;
          seq[1] = b;
          n = 2;
        end else begin
          seq[0] = b;
          n = 1;
        end
      end
      cte_pkg::MODE_FIELD, cte_pkg::MODE_NULL: begin
        if (sep_pending) begin
          seq[n] = delim_now;
          n++;
        end
        sep_pending = 1'b1;
        if (mode == cte_pkg::MODE_NULL) begin
          seq[n] = cte_pkg::BACKSLASH;
          seq[n + 1] = cte_pkg::LETTER_N;
          n += 2;
        end
      end
      default: sep_pending = 1'b0;
    endcase
    for (int i = 0; i < n; i++)
      text_due.push_back('{value: seq[i], last: (i == n - 1)});
  endtask

  // Monitor and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      delim_now = cte_pkg::DELIM_RESET;
      sep_pending = 1'b0;
      in_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (text_due.size() == 0) begin
          $display("%0t: unexpected output: expected none, got byte %h last %b",
                   $time, out_byte, out_last);
          mismatches++;
        end else begin
          got_byte = text_due.pop_front();
          if (out_byte !== got_byte.value || out_last !== got_byte.last) begin
            $display("%0t: output mismatch: expected byte %h last %b, got byte %h last %b",
                     $time, got_byte.value, got_byte.last, out_byte, out_last);
            mismatches++;
          end
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken)
        predict_text(cte_pkg::mode_t'(in_mode), in_data_byte);
      if (cfg_wr_en)
        delim_now = cfg_wr_data;
    end
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = req_queue.pop_front();
          in_valid <= 1'b1;
          in_mode <= next_req.mode;
          in_data_byte <= next_req.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic queue_request(input cte_pkg::mode_t mode, input logic [7:0] b);
    req_queue.push_back('{mode: mode, data: b});
  endtask

  // Well-formed rows with random content, plus some noise requests
  task automatic queue_random_rows(input int n, input logic [7:0] delim);
    logic [7:0] special_bytes[11];
    int         count;
    int         nbytes;
    special_bytes = '{8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B, cte_pkg::BACKSLASH,
                      8'h00, 8'hFF, cte_pkg::LETTER_N, 8'h00};
    special_bytes[10] = delim;
    count = 0;
    while (count < n) begin
      if ($urandom_range(9) == 0) begin
        queue_request(cte_pkg::mode_t'($urandom_range(3)), 8'($urandom_range(255)));
        count++;
      end else begin
        queue_request(cte_pkg::MODE_ROW, 8'($urandom_range(255)));
        count++;
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(3) == 0) begin
            queue_request(cte_pkg::MODE_NULL, 8'($urandom_range(255)));
            count++;
          end else begin
            queue_request(cte_pkg::MODE_FIELD, 8'($urandom_range(255)));
            count++;
            nbytes = $urandom_range(0, 5);
            repeat (nbytes) begin
              if ($urandom_range(1) == 0)
                queue_request(cte_pkg::MODE_DATA, special_bytes[$urandom_range(10)]);
              else
                queue_request(cte_pkg::MODE_DATA, 8'($urandom_range(255)));
              count++;
            end
          end
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || text_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] delim_set[7];
    int         send_set[7];
    int         stall_set[7];
    delim_set = '{8'h2C, 8'h00, 8'hFF, cte_pkg::BACKSLASH, 8'h0A, cte_pkg::LETTER_N,
                  8'h7C};
    send_set  = '{0, 72, 0, 17, 0, 72, 0};
    stall_set = '{0, 0, 72, 17, 0, 0, 72};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = cte_pkg::MODE_DATA;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset delimiter is tab, so a tab in data takes its letter escape
    queue_request(cte_pkg::MODE_FIELD, 8'hFF);
    queue_request(cte_pkg::MODE_DATA, 8'h08);
    queue_request(cte_pkg::MODE_DATA, 8'h0C);
    queue_request(cte_pkg::MODE_DATA, 8'h0A);
    queue_request(cte_pkg::MODE_DATA, 8'h0D);
    queue_request(cte_pkg::MODE_DATA, 8'h09);
    queue_request(cte_pkg::MODE_DATA, 8'h0B);
    queue_request(cte_pkg::MODE_DATA, cte_pkg::BACKSLASH);
    queue_request(cte_pkg::MODE_DATA, 8'h00);
    queue_request(cte_pkg::MODE_DATA, 8'hFF);
    queue_request(cte_pkg::MODE_DATA, cte_pkg::LETTER_N);
    queue_request(cte_pkg::MODE_FIELD, 8'h00);
    queue_request(cte_pkg::MODE_NULL, 8'hAA);
    queue_request(cte_pkg::MODE_NULL, 8'h55);
    queue_request(cte_pkg::MODE_ROW, 8'hFF);
    queue_request(cte_pkg::MODE_NULL, 8'h00);
    queue_request(cte_pkg::MODE_FIELD, 8'h00);
    queue_request(cte_pkg::MODE_ROW, 8'h00);
    queue_request(cte_pkg::MODE_ROW, 8'h00);
    queue_request(cte_pkg::MODE_DATA, 8'h41);
    queue_request(cte_pkg::MODE_FIELD, 8'h00);
    queue_request(cte_pkg::MODE_FIELD, 8'h00);
    wait_drained();

    write_delimiter(8'h2C);
    queue_request(cte_pkg::MODE_DATA, 8'h2C);
    queue_request(cte_pkg::MODE_DATA, 8'h09);
    queue_request(cte_pkg::MODE_FIELD, 8'h00);
    wait_drained();

    foreach (delim_set[i]) begin
      send_idle_pct = send_set[i];
      stall_pct = stall_set[i];
      write_delimiter(delim_set[i]);
      queue_random_rows(40, delim_set[i]);
      wait_drained();
    end

    if (mismatches == 0)
      $display("copy_text_row_escaper_test OK");
    else
      $display("copy_text_row_escaper_test NOT OK");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("copy_text_row_escaper_test NOT OK");
    $finish;
  end

endmodule
